// ===== rtl/cnp_pkg.sv =====
package cnp_pkg;

	localparam int PKT_LEN    = 36;
	localparam int PREFIX_LEN = 25;
	localparam int DIGITS     = 10;
	localparam int BIN_W      = 32;
	localparam int STEP_W     = $clog2(BIN_W);
	localparam int CURSOR_W   = 6;
	localparam int HEAD_IDX_W = $clog2(PREFIX_LEN);
	localparam int DIGIT_IDX_W = $clog2(DIGITS);

	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
	localparam logic [31:0] TIMEOUT_BAD   = 32'h8000_0000;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	localparam logic [1:0] STATUS_IDLE  = 2'd0;
	localparam logic [1:0] STATUS_BUSY  = 2'd1;
	localparam logic [1:0] STATUS_FAULT = 2'd2;

	// Fixed notification header: array of 3, msgid 2, "mon/write", array of 1,
	// 22-byte string opening with the counter label.
	localparam logic [7:0] HEAD_BYTES [PREFIX_LEN] = '{
		8'h93, 8'h02, 8'ha9, 8'h6d, 8'h6f, 8'h6e, 8'h2f, 8'h77, 8'h72, 8'h69,
		8'h74, 8'h65, 8'h91, 8'hb6, 8'h50, 8'h30, 8'h20, 8'h63, 8'h6f, 8'h75,
		8'h6e, 8'h74, 8'h65, 8'h72, 8'h3d
	};

	typedef enum logic [1:0] {
		FUNC_SUBMIT   = 2'd0,
		FUNC_ACCEPT   = 2'd1,
		FUNC_COMPLETE = 2'd2,
		FUNC_TICK     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_BUSY  = 3'b010,
		MODE_FAULT = 3'b100
	} mode_t;

	typedef logic [DIGITS-1:0][3:0] digits_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] counter_value;
		logic [31:0] time_now;
		logic [7:0]  accept_count;
	} cnp_in_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] byte_value;
		logic       byte_valid;
		logic [1:0] status_code;
		logic [5:0] bytes_left;
	} cnp_out_t;

endpackage

// ===== rtl/cnp_bcd_conv.sv =====
module cnp_bcd_conv (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cnp_pkg::BIN_W-1:0] value,
	output logic                     busy,
	output cnp_pkg::digits_t          digits
);
	import cnp_pkg::*;

	logic [BIN_W-1:0]  bin_q;
	digits_t           bcd_q;
	digits_t           adj;
	logic [4*DIGITS:0] shifted;
	logic [STEP_W-1:0] step_q;
	logic              run_q;

	// Shift-and-add-3: correct every digit, then shift one binary bit in.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// Drop the bit shifted out of the top digit.
	assign shifted = {adj, bin_q[BIN_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= STEP_W'(BIN_W - 1);
		end else if (run_q) begin
			if (step_q == '0) begin
				run_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= shifted[4*DIGITS-1:0];
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end
	end

	assign busy   = run_q;
	assign digits = bcd_q;

endmodule

// ===== rtl/counter_notification_packetizer.sv =====
// Counter notification packetizer.
// Input channel in_valid/in_stall/in_data carries one command beat: submit,
// byte accepted, complete or time tick. Every command beat yields exactly
// one result beat on out_valid/out_stall/out_data with ok, the packet byte
// at the cursor, its valid flag, the status and the bytes still to send.
// A submit taken while idle runs a 32-step shift-and-add-3 conversion that
// corrects all ten digits in parallel at every step; the next beat is taken
// only once its result has moved into the output register. Every other
// command's result is formed from the registered beat, and the next beat is
// likewise taken only once that result has moved into the output register.
// The user writes the timeout register via cfg_wr_en/cfg_wr_data only
// while the block is idle; the block does not enforce this. A value of
// zero or at least 2^31 puts it into fault. Reset sets the timeout to 1000,
// the status to idle and the cursor to 0. Fault holds until reset.
// A stalled result waits in the output register; the block takes no new
// command until that result can be moved into it.
module counter_notification_packetizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cnp_pkg::cnp_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output cnp_pkg::cnp_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [31:0]       cfg_wr_data
);
	import cnp_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE = 3'b001,
		SEQ_CONV = 3'b010,
		SEQ_EMIT = 3'b100
	} seq_t;

	seq_t                seq_q;
	cnp_in_t             item_q;
	mode_t               mode_q;
	logic [CURSOR_W-1:0] cursor_q;
	logic [31:0]         start_q;
	logic [31:0]         timeout_q;
	logic                out_valid_q;
	cnp_out_t            out_q;

	logic                in_beat;
	logic                conv_start;
	logic                conv_busy;
	digits_t             digits;
	logic                emit;
	mode_t               mode_n;
	logic [CURSOR_W-1:0] cursor_n;
	logic                ok_n;
	logic [31:0]         elapsed;
	logic                busy_n;
	logic                valid_n;
	logic [7:0]          byte_n;
	logic [CURSOR_W-1:0] dig_off;
	logic [DIGIT_IDX_W-1:0] dig_idx;
	logic [1:0]          status_n;
	cnp_out_t            result;

	assign in_stall   = (seq_q != SEQ_IDLE);
	assign in_beat    = in_valid && !in_stall;
	assign conv_start = in_beat && (in_data.func == FUNC_SUBMIT) && (mode_q == MODE_IDLE);
	assign emit       = (seq_q == SEQ_EMIT) && (!out_valid_q || !out_stall);

	cnp_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (in_data.counter_value),
		.busy   (conv_busy),
		.digits (digits)
	);

	assign elapsed = item_q.time_now - start_q;

	always_comb begin
		mode_n   = mode_q;
		cursor_n = cursor_q;
		ok_n     = 1'b0;
		case (item_q.func)
			FUNC_SUBMIT: begin
				if (mode_q == MODE_IDLE) begin
					mode_n   = MODE_BUSY;
					cursor_n = '0;
					ok_n     = 1'b1;
				end
			end
			FUNC_ACCEPT: begin
				if (mode_q != MODE_BUSY || cursor_q >= CURSOR_W'(PKT_LEN)
						|| item_q.accept_count != 8'd1) begin
					mode_n = MODE_FAULT;
				end else begin
					cursor_n = cursor_q + 1'b1;
				end
			end
			FUNC_COMPLETE: begin
				if (mode_q != MODE_BUSY || cursor_q != CURSOR_W'(PKT_LEN)) begin
					mode_n = MODE_FAULT;
				end else begin
					mode_n = MODE_IDLE;
					ok_n   = 1'b1;
				end
			end
			FUNC_TICK: begin
				if (mode_q == MODE_BUSY && elapsed >= timeout_q) begin
					mode_n = MODE_FAULT;
				end
			end
			default: begin
				mode_n = MODE_FAULT;
			end
		endcase
	end

	// Packet byte at the new cursor: header, then digits, then newline.
	assign busy_n  = (mode_n == MODE_BUSY);
	assign valid_n = busy_n && (cursor_n < CURSOR_W'(PKT_LEN));
	assign dig_off = cursor_n - CURSOR_W'(PREFIX_LEN);
	assign dig_idx = DIGIT_IDX_W'(DIGITS - 1) - dig_off[DIGIT_IDX_W-1:0];

	always_comb begin
		if (!valid_n) begin
			byte_n = 8'h00;
		end else if (cursor_n < CURSOR_W'(PREFIX_LEN)) begin
			byte_n = HEAD_BYTES[cursor_n[HEAD_IDX_W-1:0]];
		end else if (cursor_n < CURSOR_W'(PREFIX_LEN + DIGITS)) begin
			byte_n = CHAR_ZERO | {4'h0, digits[dig_idx]};
		end else begin
			byte_n = CHAR_NEWLINE;
		end
	end

	always_comb begin
		case (mode_n)
			MODE_IDLE:  status_n = STATUS_IDLE;
			MODE_BUSY:  status_n = STATUS_BUSY;
			MODE_FAULT: status_n = STATUS_FAULT;
			default:    status_n = STATUS_FAULT;
		endcase
	end

	always_comb begin
		result.ok          = ok_n;
		result.byte_value  = byte_n;
		result.byte_valid  = valid_n;
		result.status_code = status_n;
		result.bytes_left  = busy_n ? (CURSOR_W'(PKT_LEN) - cursor_n) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			case (seq_q)
				SEQ_IDLE: begin
					if (conv_start) begin
						seq_q <= SEQ_CONV;
					end else if (in_beat) begin
						seq_q <= SEQ_EMIT;
					end
				end
				SEQ_CONV: begin
					if (!conv_busy) begin
						seq_q <= SEQ_EMIT;
					end
				end
				SEQ_EMIT: begin
					if (emit) begin
						seq_q <= SEQ_IDLE;
					end
				end
				default: begin
					seq_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			cursor_q  <= '0;
			start_q   <= '0;
			timeout_q <= TIMEOUT_RESET;
		end else begin
			// Bad timeout value drops the block into fault at once.
			if (cfg_wr_en && (cfg_wr_data == '0 || cfg_wr_data >= TIMEOUT_BAD)) begin
				mode_q <= MODE_FAULT;
			end else if (emit) begin
				mode_q <= mode_n;
			end
			if (emit) begin
				cursor_q <= cursor_n;
				if (ok_n && item_q.func == FUNC_SUBMIT) begin
					start_q <= item_q.time_now;
				end
			end
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_conv_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		conv_busy |-> seq_q == SEQ_CONV)
		else $error("conversion running outside its sequencer state");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CURSOR_W'(PKT_LEN))
		else $error("byte cursor past packet end");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_FAULT |=> mode_q == MODE_FAULT)
		else $error("fault left without reset");

	a_ok_not_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ok |-> out_data.status_code != STATUS_FAULT)
		else $error("ok reported with fault status");

endmodule
